[design/triangle_scanline_span_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the triangle scanline span block
// Included by the file that carries the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SCANLINE_SPAN_DEFINES_SVH
`define TRIANGLE_SCANLINE_SPAN_DEFINES_SVH

// same-cycle implication
`define TSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tss check failed");

// next-cycle implication
`define TSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("tss check failed");

`endif

[design/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// Widths, latencies and shared types of the triangle scanline span block.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

  localparam int CB         = 14;
  localparam int DIFF_W     = CB + 1;
  localparam int NUM_W      = 2 * CB + 2;
  localparam int QB         = 2 * ((CB + 1) / 2);
  localparam int DIV_STAGES = QB / 2;
  localparam int RW         = NUM_W + 1;
  localparam int EDGE_LAT   = DIV_STAGES + 4;
  localparam int SPAN_LAT   = EDGE_LAT + 1;
  localparam int SW_W       = 13;
  localparam logic [SW_W-1:0] SW_RESET = SW_W'(640);
  localparam int MRG_W      = ((CB > SW_W) ? CB : SW_W) + 2;

  typedef struct packed {
    logic                 vld;
    logic signed [CB-1:0] lo;
    logic signed [CB-1:0] hi;
  } tss_cand_t;

endpackage

`default_nettype wire

[design/tss_edge_pipe.sv]
// ----------------------------------------------------------------------------
// tss_edge_pipe
// One edge: span test, exact numerator, pipelined restoring divide (two
// quotient bits a stage), sign fix and crossing candidates.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_edge_pipe import tss_pkg::*; (
  input  logic                 clk,
  input  logic signed [CB-1:0] px,
  input  logic signed [CB-1:0] py,
  input  logic signed [CB-1:0] qx,
  input  logic signed [CB-1:0] qy,
  input  logic signed [CB-1:0] row,
  output tss_cand_t            cand
);

  // stage 1: differences
  logic signed [CB-1:0]     s1_px_r, s1_qx_r;
  logic signed [DIFF_W-1:0] s1_den_r, s1_dy_r, s1_dx_r;
  logic                     s1_spans_r, s1_horiz_r;

  always_ff @(posedge clk) begin
    s1_px_r    <= px;
    s1_qx_r    <= qx;
    s1_den_r   <= DIFF_W'(qy) - DIFF_W'(py);
    s1_dy_r    <= DIFF_W'(row) - DIFF_W'(py);
    s1_dx_r    <= DIFF_W'(qx) - DIFF_W'(px);
    s1_spans_r <= ((py <= row) && (row <= qy)) || ((qy <= row) && (row <= py));
    s1_horiz_r <= (py == qy);
  end

  // stage 2: numerator
  logic signed [2*CB:0]     p1;
  logic signed [2*CB+1:0]   p2;
  logic signed [NUM_W-1:0]  s2_num_r;
  logic signed [DIFF_W-1:0] s2_den_r;
  logic signed [CB-1:0]     s2_px_r, s2_qx_r;
  logic                     s2_spans_r, s2_horiz_r;

  assign p1 = s1_px_r * s1_den_r;
  assign p2 = s1_dy_r * s1_dx_r;

  always_ff @(posedge clk) begin
    s2_num_r   <= NUM_W'(p1) + NUM_W'(p2);
    s2_den_r   <= s1_den_r;
    s2_px_r    <= s1_px_r;
    s2_qx_r    <= s1_qx_r;
    s2_spans_r <= s1_spans_r;
    s2_horiz_r <= s1_horiz_r;
  end

  // stage 3: magnitudes, then divide stages
  logic [NUM_W-1:0]  num_abs;
  logic [DIFF_W-1:0] den_abs;

  assign num_abs = s2_num_r[NUM_W-1] ? NUM_W'(-s2_num_r) : NUM_W'(s2_num_r);
  assign den_abs = s2_den_r[DIFF_W-1] ? DIFF_W'(-s2_den_r) : DIFF_W'(s2_den_r);

  logic [NUM_W-2:0]     dv_rem_r   [0:DIV_STAGES];
  logic [QB-1:0]        dv_q_r     [0:DIV_STAGES];
  logic [CB-1:0]        dv_den_r   [0:DIV_STAGES];
  logic                 dv_neg_r   [0:DIV_STAGES];
  logic signed [CB-1:0] dv_px_r    [0:DIV_STAGES];
  logic signed [CB-1:0] dv_qx_r    [0:DIV_STAGES];
  logic                 dv_spans_r [0:DIV_STAGES];
  logic                 dv_horiz_r [0:DIV_STAGES];

  always_ff @(posedge clk) begin
    dv_rem_r[0]   <= num_abs[NUM_W-2:0];
    dv_q_r[0]     <= '0;
    dv_den_r[0]   <= den_abs[CB-1:0];
    dv_neg_r[0]   <= s2_num_r[NUM_W-1] ^ s2_den_r[DIFF_W-1];
    dv_px_r[0]    <= s2_px_r;
    dv_qx_r[0]    <= s2_qx_r;
    dv_spans_r[0] <= s2_spans_r;
    dv_horiz_r[0] <= s2_horiz_r;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [RW-1:0] rem_w;
    logic [RW-1:0] sub_w;
    logic [QB-1:0] q_w;

    always_comb begin
      rem_w = RW'(dv_rem_r[k]);
      q_w   = dv_q_r[k];
      for (int j = 0; j < 2; j++) begin
        sub_w = RW'(dv_den_r[k]) << (QB - 1 - 2 * k - j);
        if (rem_w >= sub_w) begin
          rem_w = rem_w - sub_w;
          q_w[QB-1-2*k-j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      dv_rem_r[k+1]   <= rem_w[NUM_W-2:0];
      dv_q_r[k+1]     <= q_w;
      dv_den_r[k+1]   <= dv_den_r[k];
      dv_neg_r[k+1]   <= dv_neg_r[k];
      dv_px_r[k+1]    <= dv_px_r[k];
      dv_qx_r[k+1]    <= dv_qx_r[k];
      dv_spans_r[k+1] <= dv_spans_r[k];
      dv_horiz_r[k+1] <= dv_horiz_r[k];
    end
  end

  // last stage: signed crossing, or both endpoints on a flat edge
  logic [QB-1:0]        q_sgn;
  logic signed [CB-1:0] x_cross;
  logic signed [CB-1:0] ex_px, ex_qx;

  assign ex_px   = dv_px_r[DIV_STAGES];
  assign ex_qx   = dv_qx_r[DIV_STAGES];
  assign q_sgn   = dv_neg_r[DIV_STAGES] ? QB'(-dv_q_r[DIV_STAGES]) : dv_q_r[DIV_STAGES];
  assign x_cross = q_sgn[CB-1:0];

  tss_cand_t cand_r;

  always_ff @(posedge clk) begin
    cand_r.vld <= dv_spans_r[DIV_STAGES];
    if (dv_horiz_r[DIV_STAGES]) begin
      cand_r.lo <= (ex_px < ex_qx) ? ex_px : ex_qx;
      cand_r.hi <= (ex_px > ex_qx) ? ex_px : ex_qx;
    end else begin
      cand_r.lo <= x_cross;
      cand_r.hi <= x_cross;
    end
  end

  assign cand = cand_r;

endmodule

`default_nettype wire

[design/tss_span_merge.sv]
// ----------------------------------------------------------------------------
// tss_span_merge
// Folds the candidates of every triangle edge into the span and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_span_merge import tss_pkg::*; (
  input  logic                 clk,
  input  logic [SW_W-1:0]      sw,
  input  tss_cand_t [2:0]      cands,
  output logic signed [CB-1:0] span_left,
  output logic signed [CB-1:0] span_right,
  output logic                 any_edge
);

  logic signed [MRG_W-1:0] lo, hi, c_lo, c_hi;
  logic                    any;

  always_comb begin
    lo  = signed'(MRG_W'(sw));
    hi  = '0;
    any = 1'b0;
    for (int e = 0; e < 3; e++) begin
      c_lo = MRG_W'(cands[e].lo);
      c_hi = MRG_W'(cands[e].hi);
      if (cands[e].vld) begin
        any = 1'b1;
        if (c_lo < lo) lo = c_lo;
        if (c_hi > hi) hi = c_hi;
      end
    end
  end

  logic signed [CB-1:0] left_r, right_r;
  logic                 any_r;

  always_ff @(posedge clk) begin
    left_r  <= lo[CB-1:0];
    right_r <= hi[CB-1:0];
    any_r   <= any;
  end

  assign span_left  = left_r;
  assign span_right = right_r;
  assign any_edge   = any_r;

endmodule

`default_nettype wire

[design/triangle_scanline_span.sv]
// ----------------------------------------------------------------------------
// triangle_scanline_span
// Span of one triangle on one row: leftmost and rightmost edge crossings.
//
//   channel  handshake            beat
//   in       start / busy         ax ay bx by_coord cx cy row
//   cfg      cfg_valid/cfg_ready  clip width
//   out      out_valid strobe     row_out span_left span_right any_edge
//
// One item per cycle; each input beat passes through the difference, product
// and magnitude registers, seven two-bit divide stages, then the edge
// candidate and merge registers before its result appears.
// busy stays low and cfg_ready stays high.
// Synchronous reset clears valid bits and sets the clip width to 640.
// The result is a one-cycle strobe; there is no backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_scanline_span_defines.svh"

module triangle_scanline_span import tss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CB-1:0] in_ax,
  input  logic signed [CB-1:0] in_ay,
  input  logic signed [CB-1:0] in_bx,
  input  logic signed [CB-1:0] in_by_coord,
  input  logic signed [CB-1:0] in_cx,
  input  logic signed [CB-1:0] in_cy,
  input  logic signed [CB-1:0] in_row,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SW_W-1:0]      cfg_clip_width,
  output logic                 out_valid,
  output logic signed [CB-1:0] out_row_out,
  output logic signed [CB-1:0] out_span_left,
  output logic signed [CB-1:0] out_span_right,
  output logic                 out_any_edge
);

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic [SW_W-1:0] sw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= SW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sw_r <= cfg_clip_width;
    end
  end

  logic [SPAN_LAT-1:0] vld_r;
  logic signed [CB-1:0] row_r [0:SPAN_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SPAN_LAT-2:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    row_r[0] <= in_row;
    for (int i = 1; i < SPAN_LAT; i++) row_r[i] <= row_r[i-1];
  end

  tss_cand_t [2:0] cands;

  tss_edge_pipe u_edge_ab (
    .clk(clk), .px(in_ax), .py(in_ay), .qx(in_bx), .qy(in_by_coord),
    .row(in_row), .cand(cands[0])
  );

  tss_edge_pipe u_edge_bc (
    .clk(clk), .px(in_bx), .py(in_by_coord), .qx(in_cx), .qy(in_cy),
    .row(in_row), .cand(cands[1])
  );

  tss_edge_pipe u_edge_ca (
    .clk(clk), .px(in_cx), .py(in_cy), .qx(in_ax), .qy(in_ay),
    .row(in_row), .cand(cands[2])
  );

  tss_span_merge u_merge (
    .clk(clk), .sw(sw_r), .cands(cands),
    .span_left(out_span_left), .span_right(out_span_right),
    .any_edge(out_any_edge)
  );

  assign out_valid   = vld_r[SPAN_LAT-1];
  assign out_row_out = row_r[SPAN_LAT-1];

  logic [MRG_W-1:0] sw_ext;
  logic [CB-1:0]    sw_trunc;

  assign sw_ext   = MRG_W'(sw_r);
  assign sw_trunc = sw_ext[CB-1:0];

  `TSS_ASSERT_NEXT(a_latency, start, ##(SPAN_LAT-1) out_valid)
  `TSS_ASSERT_IMPL(a_empty_right, out_valid && !out_any_edge, out_span_right == '0)
  `TSS_ASSERT_IMPL(a_empty_left, out_valid && !out_any_edge, out_span_left == sw_trunc)

endmodule

`default_nettype wire

[tb/triangle_scanline_span_tb.sv]
// ----------------------------------------------------------------------------
// triangle_scanline_span_tb
// Drives triangles and rows into the span block, predicts each span with an
// exact rational crossing calculation and compares every result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_scanline_span_tb;
  import tss_pkg::*;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy, row;
  } tri_t;

  typedef struct packed {
    coord_t row;
    coord_t left;
    coord_t right;
    logic   any;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t in_ax = '0, in_ay = '0, in_bx = '0, in_by_coord = '0;
  coord_t in_cx = '0, in_cy = '0, in_row = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [SW_W-1:0] cfg_clip_width = '0;
  logic out_valid;
  coord_t out_row_out, out_span_left, out_span_right;
  logic out_any_edge;

  tri_t  tri_q[$];
  span_t span_q[$];
  logic [SW_W-1:0] width_reg = SW_RESET;
  int errors = 0;
  int send_idle = 0;
  bit hold = 1'b0;

  triangle_scanline_span u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ax(in_ax), .in_ay(in_ay), .in_bx(in_bx), .in_by_coord(in_by_coord),
    .in_cx(in_cx), .in_cy(in_cy), .in_row(in_row),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_clip_width(cfg_clip_width),
    .out_valid(out_valid), .out_row_out(out_row_out),
    .out_span_left(out_span_left), .out_span_right(out_span_right),
    .out_any_edge(out_any_edge)
  );

  always #5 clk = ~clk;

  function automatic void cross_edge(longint px, longint py, longint qx, longint qy,
                                     longint r, inout longint lo, inout longint hi,
                                     inout bit any);
    longint num, den, x;
    if (!((py <= r && r <= qy) || (qy <= r && r <= py))) return;
    any = 1'b1;
    if (py == qy) begin
      if (px < lo) lo = px;
      if (px > hi) hi = px;
      if (qx < lo) lo = qx;
      if (qx > hi) hi = qx;
      return;
    end
    den = qy - py;
    num = px * den + (r - py) * (qx - px);
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    x = num / den;
    if (x < lo) lo = x;
    if (x > hi) hi = x;
  endfunction

  function automatic span_t predict_span(tri_t t);
    longint lo, hi;
    bit any;
    span_t s;
    lo = longint'(width_reg);
    hi = 0;
    any = 1'b0;
    cross_edge(t.ax, t.ay, t.bx, t.by, t.row, lo, hi, any);
    cross_edge(t.bx, t.by, t.cx, t.cy, t.row, lo, hi, any);
    cross_edge(t.cx, t.cy, t.ax, t.ay, t.row, lo, hi, any);
    s.row = t.row;
    s.left = coord_t'(lo);
    s.right = coord_t'(hi);
    s.any = any;
    return s;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n && !hold && tri_q.size() > 0 && !(start && busy) &&
        $urandom_range(99) >= send_idle) begin
      tri_t t;
      t = tri_q.pop_front();
      {in_ax, in_ay, in_bx, in_by_coord, in_cx, in_cy, in_row} <= t;
      start <= 1'b1;
    end else if (!(start && busy)) begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      span_q.push_back(predict_span({in_ax, in_ay, in_bx, in_by_coord, in_cx, in_cy,
                                     in_row}));
    if (rst_n && out_valid) begin
      if (span_q.size() == 0) begin
        $error("unexpected beat");
        errors++;
      end else begin
        span_t e;
        e = span_q.pop_front();
        if (out_row_out !== e.row) begin
          $error("row_out exp %0d got %0d", e.row, out_row_out); errors++;
        end
        if (out_span_left !== e.left) begin
          $error("span_left exp %0d got %0d", e.left, out_span_left); errors++;
        end
        if (out_span_right !== e.right) begin
          $error("span_right exp %0d got %0d", e.right, out_span_right); errors++;
        end
        if (out_any_edge !== e.any) begin
          $error("any_edge exp %0d got %0d", e.any, out_any_edge); errors++;
        end
      end
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 1400)) - 200);
      default: return coord_t'(int'($urandom_range(0, 60)) - 30);
    endcase
  endfunction

  task automatic add_tri(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                         coord_t cx, coord_t cy, coord_t r);
    tri_t t;
    t = '{ax, ay, bx, by, cx, cy, r};
    tri_q.push_back(t);
  endtask

  task automatic add_random(int n);
    int mode;
    coord_t lo_y, hi_y;
    tri_t t;
    repeat (n) begin
      mode = $urandom_range(2);
      t.ax = rand_coord(mode); t.ay = rand_coord(mode);
      t.bx = rand_coord(mode); t.by = rand_coord(mode);
      t.cx = rand_coord(mode); t.cy = rand_coord(mode);
      if ($urandom_range(9) == 0) t.by = t.ay;
      lo_y = t.ay; hi_y = t.ay;
      if (t.by < lo_y) lo_y = t.by;
      if (t.cy < lo_y) lo_y = t.cy;
      if (t.by > hi_y) hi_y = t.by;
      if (t.cy > hi_y) hi_y = t.cy;
      case ($urandom_range(9))
        0: t.row = rand_coord(0);
        1: t.row = t.ay;
        2: t.row = t.cy;
        default: t.row = coord_t'(longint'(lo_y) +
                                  $urandom_range(0, int'(hi_y) - int'(lo_y)));
      endcase
      tri_q.push_back(t);
    end
  endtask

  task automatic drain();
    wait (tri_q.size() == 0);
    @(posedge clk);
    @(posedge clk);
    wait (span_q.size() == 0);
    repeat (SPAN_LAT + 4) @(posedge clk);
  endtask

  task automatic write_width(logic [SW_W-1:0] w);
    @(negedge clk);
    cfg_clip_width <= w;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    width_reg = w;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset width, extremes, horizontal edges, no edge
    add_tri(-8192, -8192, 8191, 8191, -8192, 8191, 0);
    add_tri(8191, -8192, -8192, 8191, 8191, 8191, 8191);
    add_tri(0, 10, 100, 10, 50, 50, 10);
    add_tri(-5, 20, 30, 20, 7, 20, 20);
    add_tri(0, 0, 10, 10, 20, 0, 100);
    add_tri(-8192, 8191, 8191, -8192, 0, 0, -8192);
    add_tri(-100, -7, 33, 9, 5, -3, 1);
    add_tri(1000, 0, 3, 3, -999, 1, 2);
    add_tri(-1, -1, -1, -1, -1, -1, -1);
    add_tri(8191, 0, 8191, 1, 8191, 2, 1);
    add_tri(-8192, 0, -8192, 1, -8192, 2, 1);
    add_tri(5, -8192, 7, -8192, 9, 8191, -8192);
    drain();
    write_width(13'h1FFF);
    add_tri(-10, 0, 10000 - 9000, 100, 5, 50, 40);
    add_tri(0, 0, 0, 0, 0, 0, 0);
    add_tri(3, -2, 8, 5, -4, 9, 3);
    drain();
    write_width(13'd0);
    add_tri(-8192, -100, 8191, 100, 0, 0, 0);
    add_tri(1, 1, 2, 2, 3, 3, 50);
    drain();
    write_width(13'd1);

    send_idle = 7;
    add_random(500);
    drain();
    write_width(13'($urandom_range(1, 8191)));
    send_idle = 69;
    add_random(500);
    drain();
    hold = 1'b1;
    write_width(SW_RESET);
    hold = 1'b0;
    send_idle = 0;
    add_random(300);
    wait (tri_q.size() < 150);
    hold = 1'b1;
    @(posedge clk);
    wait (span_q.size() == 0);
    hold = 1'b0;
    add_random(300);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+design
design/tss_pkg.sv
design/tss_edge_pipe.sv
design/tss_span_merge.sv
design/triangle_scanline_span.sv
tb/triangle_scanline_span_tb.sv
